// ===== rtl/escape_sequence_unescaper_defines.svh =====
// Assertion macros for the escape sequence unescaper.
`ifndef ESCAPE_SEQUENCE_UNESCAPER_DEFINES_SVH
`define ESCAPE_SEQUENCE_UNESCAPER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Condition must hold at every clock edge outside reset.
`define ESU_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define ESU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ESU_ASSERT(lbl, cond, msg)
`define ESU_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/esu_pkg.sv =====
// Types and constants shared by the escape sequence unescaper modules.
package esu_pkg;

  // Length counter width; out_length field is fixed at 16 bits.
  localparam int LEN_W     = 16;
  localparam int OUT_LEN_W = 16;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [3:0] HEX_ALPHA = 4'd10;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_HI    = 2'd2,
    PH_LO    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       final_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 status;
    logic                 string_done;
    logic [OUT_LEN_W-1:0] out_length;
  } out_item_t;

  // Classified character as held in the queue.
  typedef struct packed {
    logic [7:0] chr;
    logic       fin;
    logic       is_bslash;
    logic       is_t;
    logic       is_n;
    logic       is_x;
    logic       is_hex;
    logic [3:0] hex_val;
  } chr_class_t;

endpackage

// ===== rtl/esu_front.sv =====
// Front end: classifies each incoming character for the back end.
module esu_front (
  input  esu_pkg::in_item_t   in_item,
  output esu_pkg::chr_class_t cls
);
  import esu_pkg::*;

  logic [7:0] c;
  assign c = in_item.text_char;

  always_comb begin
    cls           = '0;
    cls.chr       = c;
    cls.fin       = in_item.final_char;
    cls.is_bslash = (c == CH_BSLASH);
    cls.is_t      = (c == CH_T);
    cls.is_n      = (c == CH_N);
    cls.is_x      = (c == CH_X);
    if (c inside {[8'h30:8'h39]}) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      // a..f and A..F share the low three bits
      cls.is_hex  = 1'b1;
      cls.hex_val = HEX_ALPHA + 4'(c[2:0] - 3'd1);
    end
  end

endmodule

// ===== rtl/esu_queue.sv =====
// Two-entry queue of classified characters between front and back.
module esu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  esu_pkg::chr_class_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output esu_pkg::chr_class_t pop_data
);
  import esu_pkg::*;

  chr_class_t  mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        do_push;
  logic        do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// ===== rtl/esu_back.sv =====
// Back end: escape state machine, length counter and output register.
module esu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  esu_pkg::chr_class_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output esu_pkg::out_item_t  out_data
);
  import esu_pkg::*;

  localparam logic [LEN_W-1:0] COUNT_MAX = '1;

  phase_t           phase_r, phase_nxt;
  logic [3:0]       nib_r, nib_nxt;
  logic             disc_r, disc_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             emit;
  logic             err;
  logic [7:0]       emit_byte;
  logic [LEN_W-1:0] count_inc;
  out_item_t        res;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign count_inc = (count_r != COUNT_MAX) ? count_r + 1'b1 : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      nib_r   <= '0;
      disc_r  <= 1'b0;
      count_r <= '0;
    end else if (q_pop) begin
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
      disc_r  <= disc_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    nib_nxt   = nib_r;
    disc_nxt  = disc_r;
    count_nxt = count_r;
    emit      = 1'b0;
    err       = 1'b0;
    emit_byte = q_item.chr;
    if (disc_r) begin
      if (q_item.fin) begin
        disc_nxt = 1'b0;
      end
    end else begin
      case (phase_r)
        PH_PLAIN: begin
          if (q_item.is_bslash) begin
            if (q_item.fin) err = 1'b1;
            else            phase_nxt = PH_ESC;
          end else begin
            emit = 1'b1;
          end
        end
        PH_ESC: begin
          if (q_item.is_t) begin
            emit      = 1'b1;
            emit_byte = CH_TAB;
          end else if (q_item.is_n) begin
            emit      = 1'b1;
            emit_byte = CH_NL;
          end else if (q_item.is_bslash) begin
            emit      = 1'b1;
            emit_byte = CH_BSLASH;
          end else if (q_item.is_x && !q_item.fin) begin
            phase_nxt = PH_HI;
          end else begin
            err = 1'b1;
          end
        end
        PH_HI: begin
          if (!q_item.is_hex || q_item.fin) begin
            err = 1'b1;
          end else begin
            nib_nxt   = q_item.hex_val;
            phase_nxt = PH_LO;
          end
        end
        PH_LO: begin
          if (!q_item.is_hex) begin
            err = 1'b1;
          end else begin
            emit      = 1'b1;
            emit_byte = {nib_r, q_item.hex_val};
          end
        end
        default: err = 1'b1;
      endcase
      if (emit) begin
        phase_nxt = PH_PLAIN;
        count_nxt = count_inc;
        if (q_item.fin) begin
          nib_nxt   = '0;
          count_nxt = '0;
        end
      end
      if (err) begin
        phase_nxt = PH_PLAIN;
        nib_nxt   = '0;
        count_nxt = '0;
        disc_nxt  = !q_item.fin;
      end
    end
  end

  always_comb begin
    res             = '0;
    res.out_byte    = err ? 8'h00 : emit_byte;
    res.status      = err;
    res.string_done = err || q_item.fin;
    res.out_length  = OUT_LEN_W'(err ? count_r : count_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && (emit || err)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (emit || err)) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/escape_sequence_unescaper.sv =====
// Top level of the backslash escape decoder with \x hex escapes.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | input     | in_valid / in_ready  | in_data   (text_char, final_char)
//  out     | output    | out_valid / out_ready| out_data  (out_byte, status,
//          |           |                      |            string_done, out_length)
//
// One character per cycle sustained while the output is not stalled; the
// escape state machine in the back end retires one queued character each
// cycle the output register is free. Input passes the queue, then output reg.
// Synchronous active-low reset empties the queue and returns to plain text.
// An output stall holds the back end; the two-entry queue keeps taking
// transactions until it fills, then in_ready drops.
module escape_sequence_unescaper (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  esu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output esu_pkg::out_item_t out_data
);
  import esu_pkg::*;

`include "escape_sequence_unescaper_defines.svh"

  chr_class_t front_cls;   // classified incoming character
  chr_class_t q_item;      // head of queue
  logic       q_full;
  logic       q_valid;
  logic       q_pop;

  // Front: decode character classes and hex value up front.
  esu_front u_front (
    .in_item (in_data),
    .cls     (front_cls)
  );

  // Queue decouples acceptance from the escape state machine.
  esu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_item)
  );

  assign in_ready = !q_full;

  // Back: state machine, saturating length counter, output register.
  esu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Back end must not retire a character while a result is stalled.
  `ESU_ASSERT_IMPL(a_no_pop_on_stall, q_pop, !out_valid || out_ready, "pop during output stall")
  // Error results always close the string with a zero byte.
  `ESU_ASSERT_IMPL(a_err_closes, out_valid && out_data.status, out_data.string_done && out_data.out_byte == 8'h00, "malformed error result")
  // A good byte always counts itself.
  `ESU_ASSERT_IMPL(a_ok_len_nonzero, out_valid && !out_data.status, out_data.out_length != '0, "zero length on good byte")

endmodule
